### src/ubsb_pkg.sv
// Shared types and constants for the uniform B-spline basis evaluator.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps

package ubsb_pkg;

  // Width of the degree register as seen on the configuration port
  localparam int DEG_W = 3;
  // Degree as carried down the cell chain (covers MAX_DEGREE up to 15)
  localparam int KW = 4;
  // Integer part of t and width of the knot index
  localparam int KNOT_W = 8;

  // Control that travels with each item from cell to cell
  typedef struct packed {
    logic          zero;  // t lies outside the support: result is zero
    logic [KW-1:0] deg;   // degree k in effect for this item
  } ubsb_ctl_t;

endpackage

### src/uniform_bspline_basis.sv
// Top level of the uniform B-spline basis evaluator: degree register, cell chain, output stage.
// Depends on ubsb_pkg, ubsb_entry and ubsb_cell.
`timescale 1ns / 1ps

// Evaluates N(i,k)(t) on integer knots by the Cox-de Boor recursion. Each item
// carries knot index i and t in Q8.FRAC_BITS and returns one basis value in
// Q1.FRAC_BITS, zero outside [i, i+k+1) and saturated at 1.0. The user must
// write the degree k through the cfg port only while the block is idle; the
// block itself does not enforce it. Values above MAX_DEGREE act as MAX_DEGREE.
// The datapath is one entry cell (one register), MAX_DEGREE recursion cells (two
// registers each) and an output register; each item passes all cells whatever
// the degree, and a new item is taken every cycle while in_ready is high. Each
// slot of the chain advances on its own, so gaps close up while the output is
// stalled and in_ready falls only once every slot is full.
module uniform_bspline_basis #(
  parameter int FRAC_BITS  = 16,
  parameter int MAX_DEGREE = 7
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [ubsb_pkg::KNOT_W-1:0]            in_knot_index,
  input  logic [ubsb_pkg::KNOT_W+FRAC_BITS-1:0]  in_param_t,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [FRAC_BITS:0]                     out_basis_value,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ubsb_pkg::DEG_W-1:0]             cfg_spline_degree
);
  import ubsb_pkg::*;

  localparam int UW  = FRAC_BITS + $clog2(MAX_DEGREE + 1);
  localparam int NBW = FRAC_BITS + 2;
  localparam logic [DEG_W-1:0]   DEG_RESET = 3'd3;
  localparam logic [FRAC_BITS:0] ONE_OUT   = {1'b1, {FRAC_BITS{1'b0}}};

  logic [DEG_W-1:0]              deg_r;
  logic [KW-1:0]                 deg_k;

  logic [MAX_DEGREE:0]           ch_valid;
  logic [MAX_DEGREE:0]           ch_ready;
  ubsb_ctl_t                     ch_ctl [0:MAX_DEGREE];
  logic [UW-1:0]                 ch_u   [0:MAX_DEGREE];
  logic [MAX_DEGREE:0][NBW-1:0]  ch_nb  [0:MAX_DEGREE];

  logic                          out_valid_r;
  logic [FRAC_BITS:0]            basis_nxt;
  logic [FRAC_BITS:0]            basis_r;

  // Degree register; the port never stalls a write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r <= DEG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      deg_r <= cfg_spline_degree;
    end
  end

  // Saturate the degree to what the chain supports
  assign deg_k = (KW'(deg_r) > KW'(MAX_DEGREE)) ? KW'(MAX_DEGREE) : KW'(deg_r);

  ubsb_entry #(
    .FRAC_BITS  (FRAC_BITS),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_entry (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_knot_index (in_knot_index),
    .in_param_t    (in_param_t),
    .deg           (deg_k),
    .out_valid     (ch_valid[0]),
    .out_ready     (ch_ready[0]),
    .out_ctl       (ch_ctl[0]),
    .out_u         (ch_u[0]),
    .out_nb        (ch_nb[0])
  );

  // One cell per recursion level
  for (genvar d = 1; d <= MAX_DEGREE; d++) begin : g_lvl
    ubsb_cell #(
      .FRAC_BITS  (FRAC_BITS),
      .MAX_DEGREE (MAX_DEGREE),
      .LEVEL      (d)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (ch_valid[d-1]),
      .in_ready  (ch_ready[d-1]),
      .in_ctl    (ch_ctl[d-1]),
      .in_u      (ch_u[d-1]),
      .in_nb     (ch_nb[d-1]),
      .out_valid (ch_valid[d]),
      .out_ready (ch_ready[d]),
      .out_ctl   (ch_ctl[d]),
      .out_u     (ch_u[d]),
      .out_nb    (ch_nb[d])
    );
  end

  // Result: zero outside the support, otherwise the first term clamped at one
  always_comb begin
    if (ch_ctl[MAX_DEGREE].zero) begin
      basis_nxt = '0;
    end else if (ch_nb[MAX_DEGREE][0] > NBW'(ONE_OUT)) begin
      basis_nxt = ONE_OUT;
    end else begin
      basis_nxt = ch_nb[MAX_DEGREE][0][FRAC_BITS:0];
    end
  end

  // Output register
  assign ch_ready[MAX_DEGREE] = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ch_ready[MAX_DEGREE]) begin
      out_valid_r <= ch_valid[MAX_DEGREE];
    end
  end

  always_ff @(posedge clk) begin
    if (ch_valid[MAX_DEGREE] && ch_ready[MAX_DEGREE]) begin
      basis_r <= basis_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_basis_value = basis_r;

`ifndef SYNTHESIS
  // A result never exceeds one
  a_basis_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_basis_value <= ONE_OUT))
    else $error("basis value above one");

  // Input stalls only when every slot is full and the output is blocked
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && (&ch_valid)))
    else $error("input stalled with room in the chain");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

### src/ubsb_entry.sv
// Front cell of the chain: forms u = t - i, the support check and the degree-zero terms.
// Depends on ubsb_pkg.
`timescale 1ns / 1ps

module ubsb_entry #(
  parameter int FRAC_BITS  = 16,
  parameter int MAX_DEGREE = 7
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 in_valid,
  output logic                                                 in_ready,
  input  logic [ubsb_pkg::KNOT_W-1:0]                          in_knot_index,
  input  logic [ubsb_pkg::KNOT_W+FRAC_BITS-1:0]                in_param_t,
  input  logic [ubsb_pkg::KW-1:0]                              deg,
  output logic                                                 out_valid,
  input  logic                                                 out_ready,
  output ubsb_pkg::ubsb_ctl_t                                  out_ctl,
  output logic [FRAC_BITS+$clog2(MAX_DEGREE+1)-1:0]            out_u,
  output logic [MAX_DEGREE:0][FRAC_BITS+1:0]                   out_nb
);
  import ubsb_pkg::*;

  localparam int UW  = FRAC_BITS + $clog2(MAX_DEGREE + 1);
  localparam int NBW = FRAC_BITS + 2;
  localparam int TW  = KNOT_W + FRAC_BITS;
  localparam logic [NBW-1:0] ONE_NB = {2'b01, {FRAC_BITS{1'b0}}};

  logic [TW:0]                    u_full;
  logic [KNOT_W-1:0]              ipart;
  ubsb_ctl_t                      ctl_nxt;
  logic [MAX_DEGREE:0][NBW-1:0]   nb_nxt;

  logic                           v_r;
  ubsb_ctl_t                      ctl_r;
  logic [UW-1:0]                  u_r;
  logic [MAX_DEGREE:0][NBW-1:0]   nb_r;

  // Offset of t from the knot; top bit set means t is before the knot
  assign u_full = {1'b0, in_param_t} - {1'b0, in_knot_index, {FRAC_BITS{1'b0}}};
  assign ipart  = u_full[TW-1:FRAC_BITS];

  // Drop items outside [i, i+k+1) to zero
  assign ctl_nxt.zero = u_full[TW] || (ipart > KNOT_W'(deg));
  assign ctl_nxt.deg  = deg;

  // Degree-zero terms: one in the unit interval that holds u
  for (genvar m = 0; m <= MAX_DEGREE; m++) begin : g_ind
    assign nb_nxt[m] = (ipart == KNOT_W'(m)) ? ONE_NB : '0;
  end

  // Advance when the next cell can take the item or this slot is empty
  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ctl_r <= ctl_nxt;
      u_r   <= u_full[UW-1:0];
      nb_r  <= nb_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_ctl   = ctl_r;
  assign out_u     = u_r;
  assign out_nb    = nb_r;

endmodule

### src/ubsb_cell.sv
// One recursion level of the Cox-de Boor chain: blends neighboring terms of the
// previous level with weights (u-m) and (m+LEVEL+1-u), then divides by LEVEL*one.
// Depends on ubsb_pkg.
`timescale 1ns / 1ps

module ubsb_cell #(
  parameter int FRAC_BITS  = 16,
  parameter int MAX_DEGREE = 7,
  parameter int LEVEL      = 1
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  ubsb_pkg::ubsb_ctl_t                        in_ctl,
  input  logic [FRAC_BITS+$clog2(MAX_DEGREE+1)-1:0]  in_u,
  input  logic [MAX_DEGREE:0][FRAC_BITS+1:0]         in_nb,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output ubsb_pkg::ubsb_ctl_t                        out_ctl,
  output logic [FRAC_BITS+$clog2(MAX_DEGREE+1)-1:0]  out_u,
  output logic [MAX_DEGREE:0][FRAC_BITS+1:0]         out_nb
);
  import ubsb_pkg::*;

  localparam int UW  = FRAC_BITS + $clog2(MAX_DEGREE + 1);
  localparam int WW  = UW + 1;             // weight magnitude
  localparam int NBW = FRAC_BITS + 2;      // term of one level
  localparam int PW  = WW + NBW + 1;       // weighted sum
  localparam int NW  = PW + 1 - FRAC_BITS; // rounded sum after the shift
  localparam int L2  = $clog2(LEVEL);
  localparam int S   = NW + L2;            // reciprocal shift
  localparam int RW  = S + 1;
  localparam logic [63:0] RECIP64 = ((64'd1 << S) + 64'(LEVEL - 1)) / 64'(LEVEL);
  localparam logic [RW-1:0] RECIP = RECIP64[RW-1:0];
  localparam logic [PW:0]   HALF  = (PW + 1)'(LEVEL) << (FRAC_BITS - 1);

  logic [MAX_DEGREE:0][PW-1:0]  num_nxt;
  logic [MAX_DEGREE:0][NBW-1:0] nb_nxt;
  logic                         active;
  logic                         s1_ready;
  logic                         s2_ready;

  logic                         s1_v_r;
  ubsb_ctl_t                    s1_ctl_r;
  logic [UW-1:0]                s1_u_r;
  logic [MAX_DEGREE:0][NBW-1:0] s1_nb_r;
  logic [MAX_DEGREE:0][PW-1:0]  s1_num_r;

  logic                         s2_v_r;
  ubsb_ctl_t                    s2_ctl_r;
  logic [UW-1:0]                s2_u_r;
  logic [MAX_DEGREE:0][NBW-1:0] s2_nb_r;

  // Weighted sums, one lane per basis term still needed at this level
  for (genvar m = 0; m <= MAX_DEGREE; m++) begin : g_mul
    if (m <= MAX_DEGREE - LEVEL) begin : g_on
      logic [WW:0]       wa;
      logic [WW:0]       wb;
      logic [PW-2:0]     ta;
      logic [PW-2:0]     tb;
      assign wa = {2'b00, in_u} - ((WW + 1)'(m) << FRAC_BITS);
      assign wb = ((WW + 1)'(m + LEVEL + 1) << FRAC_BITS) - {2'b00, in_u};
      // Use a weight only where it is positive
      assign ta = (!wa[WW] && (|wa)) ? wa[WW-1:0] * in_nb[m] : '0;
      assign tb = (!wb[WW] && (|wb)) ? wb[WW-1:0] * in_nb[m+1] : '0;
      assign num_nxt[m] = {1'b0, ta} + {1'b0, tb};
    end else begin : g_off
      assign num_nxt[m] = '0;
    end
  end

  // Two-slot pipeline with bubble collapsing
  assign s2_ready = !s2_v_r || out_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_valid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_ctl_r <= in_ctl;
      s1_u_r   <= in_u;
      s1_nb_r  <= in_nb;
      s1_num_r <= num_nxt;
    end
  end

  // Level applies only up to the item's degree; above it, hold the terms
  assign active = (s1_ctl_r.deg >= KW'(LEVEL));

  // Round to nearest and divide by LEVEL through a reciprocal multiply
  for (genvar m = 0; m <= MAX_DEGREE; m++) begin : g_div
    if (m <= MAX_DEGREE - LEVEL) begin : g_on
      logic [PW:0]      rsum;
      logic [NW-1:0]    nq;
      logic [NW+RW-1:0] prod;
      assign rsum = {1'b0, s1_num_r[m]} + HALF;
      assign nq   = rsum[PW:FRAC_BITS];
      assign prod = nq * RECIP;
      assign nb_nxt[m] = active ? prod[S +: NBW] : s1_nb_r[m];
    end else begin : g_off
      assign nb_nxt[m] = s1_nb_r[m];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s2_ready) begin
      s2_ctl_r <= s1_ctl_r;
      s2_u_r   <= s1_u_r;
      s2_nb_r  <= nb_nxt;
    end
  end

  assign out_valid = s2_v_r;
  assign out_ctl   = s2_ctl_r;
  assign out_u     = s2_u_r;
  assign out_nb    = s2_nb_r;

endmodule

### tb/tb_top.sv
// Self-checking testbench for uniform_bspline_basis: directed table, then random items per degree.
// Depends on ubsb_pkg and the RTL in src; the expected values come from a predictor in this file.
`timescale 1ns / 1ps

module tb_top;
  import ubsb_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int MAX_DEGREE = 7;
  localparam longint ONE_FX = 64'sd1 << FRAC_BITS;
  localparam int T_W = KNOT_W + FRAC_BITS;
  localparam int NUM_DIRECTED = 21;
  localparam int ITEMS_PER_DEGREE = 250;
  localparam int DRAIN_CYCLES = 2 * MAX_DEGREE + 20;

  // One directed row: degree in effect, item fields, and a hand-typed value where obvious
  typedef struct packed {
    logic [DEG_W-1:0]  deg;
    logic [KNOT_W-1:0] knot;
    logic [T_W-1:0]    t;
    logic              typed;
    logic [FRAC_BITS:0] value;
  } basis_row_t;

  localparam basis_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // reset degree (cubic): support edges and extremes of both fields
    '{3'd3, 8'd0,   24'h000000, 1'b0, 17'd0},
    '{3'd3, 8'd5,   24'h04FFFF, 1'b1, 17'd0},
    '{3'd3, 8'd5,   24'h090000, 1'b1, 17'd0},
    '{3'd3, 8'd5,   24'h08FFFF, 1'b0, 17'd0},
    '{3'd3, 8'd5,   24'h070000, 1'b0, 17'd0},
    '{3'd3, 8'd0,   24'h020000, 1'b0, 17'd0},
    '{3'd3, 8'd255, 24'hFFFFFF, 1'b0, 17'd0},
    '{3'd3, 8'd0,   24'hFFFFFF, 1'b1, 17'd0},
    '{3'd3, 8'd255, 24'h000000, 1'b1, 17'd0},
    // degree zero: unit indicator of [i, i+1)
    '{3'd0, 8'd3,   24'h030000, 1'b1, 17'h10000},
    '{3'd0, 8'd3,   24'h03FFFF, 1'b1, 17'h10000},
    '{3'd0, 8'd3,   24'h040000, 1'b1, 17'd0},
    '{3'd0, 8'd255, 24'hFFFFFF, 1'b1, 17'h10000},
    '{3'd0, 8'd0,   24'h000000, 1'b1, 17'h10000},
    // top degree: center, past support, last step before the end
    '{3'd7, 8'd0,   24'h040000, 1'b0, 17'd0},
    '{3'd7, 8'd0,   24'h080000, 1'b1, 17'd0},
    '{3'd7, 8'd0,   24'h07FFFF, 1'b0, 17'd0},
    '{3'd7, 8'd248, 24'hFFFFFF, 1'b0, 17'd0},
    '{3'd7, 8'd1,   24'h010001, 1'b0, 17'd0},
    // linear hat: peak is exactly one
    '{3'd1, 8'd2,   24'h030000, 1'b1, 17'h10000},
    '{3'd1, 8'd2,   24'h028000, 1'b0, 17'd0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KNOT_W-1:0] in_knot_index = '0;
  logic [T_W-1:0] in_param_t = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [FRAC_BITS:0] out_basis_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [DEG_W-1:0] cfg_spline_degree = '0;

  logic [DEG_W-1:0] degree_now = 3'd3;
  logic [FRAC_BITS:0] basis_expect_q [$];
  logic [FRAC_BITS:0] basis_want;
  int mismatches = 0;
  int send_idle = 0;
  int recv_idle = 0;

  uniform_bspline_basis #(
    .FRAC_BITS(FRAC_BITS),
    .MAX_DEGREE(MAX_DEGREE)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_knot_index(in_knot_index),
    .in_param_t(in_param_t),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_basis_value(out_basis_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_spline_degree(cfg_spline_degree)
  );

  always #1 clk = ~clk;

  // Cox-de Boor on integer knots, exact sums, round half up at each level
  function automatic logic [FRAC_BITS:0] predict_basis(logic [KNOT_W-1:0] knot,
                                                       logic [T_W-1:0] t,
                                                       logic [DEG_W-1:0] deg);
    longint nb [0:MAX_DEGREE+1];
    longint u;
    longint wa;
    longint wb;
    longint num;
    longint den;
    longint res;
    int k;
    int m;
    int d;
    k = (int'(deg) > MAX_DEGREE) ? MAX_DEGREE : int'(deg);
    u = longint'(t) - longint'(knot) * ONE_FX;
    if (u < 0 || u >= longint'(k + 1) * ONE_FX) return '0;
    for (m = 0; m <= k; m++)
      nb[m] = (u >= m * ONE_FX && u < (m + 1) * ONE_FX) ? ONE_FX : 64'sd0;
    for (d = 1; d <= k; d++) begin
      den = d * ONE_FX;
      for (m = 0; m <= k - d; m++) begin
        wa = u - m * ONE_FX;
        wb = (m + d + 1) * ONE_FX - u;
        num = 0;
        if (wa > 0) num += wa * nb[m];
        if (wb > 0) num += wb * nb[m + 1];
        nb[m] = (num + den / 2) / den;
      end
    end
    res = nb[0];
    if (res > ONE_FX) res = ONE_FX;
    if (res < 0) res = 0;
    return res[FRAC_BITS:0];
  endfunction

  // Send one item after a random gap; record its expected value on acceptance
  task automatic send_item(logic [KNOT_W-1:0] knot, logic [T_W-1:0] t,
                           logic typed, logic [FRAC_BITS:0] value);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_knot_index <= knot;
    in_param_t <= t;
    do @(posedge clk); while (!in_ready);
    basis_expect_q.insert(basis_expect_q.size(),
                          typed ? value : predict_basis(knot, t, degree_now));
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected item has come back
  task automatic drain_items();
    in_valid <= 1'b0;
    while (basis_expect_q.size() != 0) @(negedge clk);
  endtask

  // Write the degree register; only called with the block idle
  task automatic write_degree(logic [DEG_W-1:0] deg);
    cfg_valid <= 1'b1;
    cfg_spline_degree <= deg;
    do @(posedge clk); while (!cfg_ready);
    degree_now = deg;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (basis_expect_q.size() == 0) begin
        $error("basis_value: expected none, got %0d", out_basis_value);
        mismatches++;
      end else begin
        basis_want = basis_expect_q.pop_front();
        if (out_basis_value !== basis_want) begin
          $error("basis_value: expected %0d, got %0d", basis_want, out_basis_value);
          mismatches++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random items for each degree
  initial begin
    int degree_order [8];
    int seg;
    int n;
    int sel;
    int deg;
    int knot_i;
    int t_i;
    degree_order = '{0, 7, 1, 6, 2, 5, 3, 4};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle = 18;
    recv_idle = 63;
    for (n = 0; n < NUM_DIRECTED; n++) begin
      if (DIRECTED_ROWS[n].deg != degree_now) begin
        drain_items();
        write_degree(DIRECTED_ROWS[n].deg);
      end
      send_item(DIRECTED_ROWS[n].knot, DIRECTED_ROWS[n].t,
                DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].value);
    end

    for (seg = 0; seg < 8; seg++) begin
      // sender light / receiver heavy, then swapped, then no idling
      if (seg < 3) begin
        send_idle = 18;
        recv_idle = 63;
      end else if (seg < 6) begin
        send_idle = 63;
        recv_idle = 18;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      drain_items();
      deg = degree_order[seg];
      write_degree(deg[DEG_W-1:0]);
      for (n = 0; n < ITEMS_PER_DEGREE; n++) begin
        sel = $urandom_range(99);
        if (sel < 70) begin
          // inside the support of a knot that keeps t within range
          knot_i = $urandom_range(255 - deg);
          t_i = knot_i * 65536 + $urandom_range((deg + 1) * 65536 - 1);
        end else if (sel < 85) begin
          // on or right beside an integer knot
          knot_i = $urandom_range(255);
          t_i = knot_i * 65536 + $urandom_range(deg + 1) * 65536
                + $urandom_range(2) - 1;
          if (t_i < 0) t_i = 0;
          if (t_i > 24'hFFFFFF) t_i = 24'hFFFFFF;
        end else begin
          knot_i = $urandom_range(255);
          t_i = $urandom() & 24'hFFFFFF;
        end
        send_item(knot_i[KNOT_W-1:0], t_i[T_W-1:0], 1'b0, '0);
      end
    end

    drain_items();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (basis_expect_q.size() != 0) begin
      $error("basis_value: %0d expected items never arrived", basis_expect_q.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #1000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
